FILE: hdl/assert_macros.svh
// assertion helpers used by the datapath
// every check is sampled on the rising edge of clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define FBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies a result in the next cycle
`define FBS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Types and constants shared by the framed bit serializer controller,
// datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbs_pkg;

  // bit counter width, holds the longest preamble
  localparam int CNT_W        = 6;
  localparam int MAX_PREAMBLE = 34;
  localparam int FRAME_LEN    = 10;
  localparam int TRAILER_LEN  = 10;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_BYTE,
    ST_CRC,
    ST_TRAIL
  } state_t;

  // source of a shift register load
  typedef enum logic [1:0] {
    SRC_ONES,
    SRC_IN,
    SRC_BYTE,
    SRC_CRC
  } src_t;

  // controller to datapath commands
  typedef struct packed {
    logic             accept;     // latch the input request
    logic             emit;       // push one bit into the output register
    logic             shift_load; // reload shift register and bit counter
    src_t             src;
    logic [CNT_W-1:0] cnt_val;
    logic             flag_last;  // bit ends the run of this request
    logic             flag_done;  // bit ends the block
    logic             close;      // clear crc and block-open flag
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic has;
    logic last;
    logic in_block;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/fbs_datapath.sv
// ----------------------------------------------------------------------------
// fbs_datapath
// Input latch, crc-8 accumulator, ten-bit shift register, bit counter and
// output register of the framed bit serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fbs_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fbs_pkg::dp_cmd_t cmd,
  output fbs_pkg::dp_sts_t     sts,
  input  wire logic [7:0]      in_tdata,   // data_byte[7:0]
  input  wire logic [0:0]      in_tuser,   // has_byte
  input  wire logic            in_tlast,   // last_byte
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,  // line_bit, zero padding [7:1]
  output logic [0:0]           out_tuser,  // frame_done
  output logic                 out_tlast   // last_of_run
);
  import fbs_pkg::*;

  // one crc-8 byte step, msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]       byte_r;
  logic             has_r, last_r;
  logic [7:0]       crc_r;
  logic             in_block_r;
  logic [9:0]       shift_r, shift_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r, out_bit_r, out_last_r, out_done_r;

  // request latch, payload only
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_tdata;
      has_r  <= in_tuser[0];
      last_r <= in_tlast;
    end
  end

  // crc and block-open flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= 8'h00;
      in_block_r <= 1'b0;
    end else if (cmd.close) begin
      crc_r      <= 8'h00;
      in_block_r <= 1'b0;
    end else if (cmd.accept) begin
      in_block_r <= 1'b1;
      if (in_tuser[0]) begin
        crc_r <= crc_step(crc_r, in_tdata);
      end
    end
  end

  // shift register load selection
  always_comb begin
    unique case (cmd.src)
      SRC_ONES: shift_nxt = '1;
      SRC_IN:   shift_nxt = {1'b1, in_tdata, 1'b0};
      SRC_BYTE: shift_nxt = {1'b1, byte_r, 1'b0};
      SRC_CRC:  shift_nxt = {1'b1, crc_r, 1'b0};
      default:  shift_nxt = '1;
    endcase
  end

  // shift register and bit counter, ones shift in from the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.shift_load) begin
      cnt_r <= cmd.cnt_val;
    end else if (cmd.emit) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_load) begin
      shift_r <= shift_nxt;
    end else if (cmd.emit) begin
      shift_r <= {1'b1, shift_r[9:1]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bit_r  <= shift_r[0];
      out_last_r <= cmd.flag_last;
      out_done_r <= cmd.flag_done;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_bit_r};
  assign out_tuser[0] = out_done_r;
  assign out_tlast    = out_last_r;

  // status back to the controller
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.cnt_last = (cnt_r == CNT_W'(1));
  assign sts.has      = has_r;
  assign sts.last     = last_r;
  assign sts.in_block = in_block_r;

  // checks
  `FBS_ASSERT(a_emit_free, !cmd.emit || sts.out_free, "bit emitted into a full output register")
  `FBS_ASSERT(a_done_last, !(out_valid_r && out_done_r) || out_last_r,
              "frame end without end of run")
  `FBS_ASSERT_NEXT(a_close_clear, cmd.close, (crc_r == 8'h00) && !in_block_r,
                   "block close left crc or block flag set")
  `FBS_ASSERT(a_crc_open, !(cmd.shift_load && cmd.src == SRC_CRC) || in_block_r || cmd.accept,
              "crc framed outside a block")

endmodule

`default_nettype wire

FILE: hdl/fbs_ctrl.sv
// ----------------------------------------------------------------------------
// fbs_ctrl
// Sequencer of the framed bit serializer: walks preamble, data frame,
// crc frame and trailer, and issues commands to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbs_ctrl #(
  parameter int PREAMBLE_LEN = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [0:0]       in_tuser,   // has_byte
  input  wire logic             in_tlast,   // last_byte
  output fbs_pkg::dp_cmd_t      cmd,
  input  wire fbs_pkg::dp_sts_t sts
);
  import fbs_pkg::*;

  // preamble length, clamped so one request stays within 64 bits
  localparam int PRE_N = (PREAMBLE_LEN > MAX_PREAMBLE) ? MAX_PREAMBLE : PREAMBLE_LEN;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.emit       = 1'b0;
    cmd.shift_load = 1'b0;
    cmd.src        = SRC_ONES;
    cmd.cnt_val    = CNT_W'(FRAME_LEN);
    cmd.flag_last  = 1'b0;
    cmd.flag_done  = 1'b0;
    cmd.close      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // idle requests carry neither byte nor end and are dropped
        if (in_tvalid && (in_tuser[0] || in_tlast)) begin
          cmd.accept     = 1'b1;
          cmd.shift_load = 1'b1;
          if (!sts.in_block && PRE_N != 0) begin
            cmd.src     = SRC_ONES;
            cmd.cnt_val = CNT_W'(PRE_N);
            state_nxt   = ST_PRE;
          end else if (in_tuser[0]) begin
            cmd.src   = SRC_IN;
            state_nxt = ST_BYTE;
          end else begin
            cmd.src   = SRC_CRC;
            state_nxt = ST_CRC;
          end
        end
      end
      ST_PRE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.cnt_last) begin
            cmd.shift_load = 1'b1;
            if (sts.has) begin
              cmd.src   = SRC_BYTE;
              state_nxt = ST_BYTE;
            end else begin
              cmd.src   = SRC_CRC;
              state_nxt = ST_CRC;
            end
          end
        end
      end
      ST_BYTE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.flag_last = sts.cnt_last && !sts.last;
          if (sts.cnt_last) begin
            if (sts.last) begin
              cmd.shift_load = 1'b1;
              cmd.src        = SRC_CRC;
              state_nxt      = ST_CRC;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_CRC: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.cnt_last) begin
            cmd.close      = 1'b1;
            cmd.shift_load = 1'b1;
            cmd.src        = SRC_ONES;
            cmd.cnt_val    = CNT_W'(TRAILER_LEN);
            state_nxt      = ST_TRAIL;
          end
        end
      end
      ST_TRAIL: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.flag_last = sts.cnt_last;
          cmd.flag_done = sts.cnt_last;
          if (sts.cnt_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/framed_bit_serializer_crc8.sv
// output: a taken request loads the shift register, whose bits then pass through the output register
// throughput: one line bit per cycle from the shift register while the output register is free; a data
//   byte is 10 bits and the accept cycle sends none, a closing request adds 20 bits of crc frame and trailer,
//   and the first request of a block adds PREAMBLE_LEN bits (clamped to 34); requests are taken only in idle
// reset: synchronous active-low rst_n clears the sequencer, crc, block flag, bit counter and output valid
// ----------------------------------------------------------------------------
// framed_bit_serializer_crc8
// Serializes block bytes into uart-style framed line bits with a preamble,
// a framed crc-8 (poly 0x07) at block end and a trailer of ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_bit_serializer_crc8 #(
  parameter int PREAMBLE_LEN = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_byte[7:0]
  input  wire logic [0:0] in_tuser,   // has_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // line_bit, zero padding [7:1]
  output logic [0:0]      out_tuser,  // frame_done
  output logic            out_tlast   // last_of_run
);
  import fbs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  fbs_ctrl #(
    .PREAMBLE_LEN(PREAMBLE_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  fbs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
